/* sv/bmpd_pkg.sv */
// bmpd_pkg: shared types, header constants and the gamma table builder
// for the BMP pixel stream decoder. No dependencies.
package bmpd_pkg;

    // Result word kinds
    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_BAD    = 2'd2
    } t_kind;

    localparam logic [7:0] MAGIC_B = 8'h42;  // 'B'
    localparam logic [7:0] MAGIC_M = 8'h4D;  // 'M'

    // Header byte offsets (14-byte file header + 40-byte info header)
    localparam logic [5:0] HDR_MAGIC_0  = 6'd0;
    localparam logic [5:0] HDR_MAGIC_1  = 6'd1;
    localparam logic [5:0] HDR_WIDTH_0  = 6'd18;
    localparam logic [5:0] HDR_WIDTH_1  = 6'd19;
    localparam logic [5:0] HDR_WIDTH_2  = 6'd20;
    localparam logic [5:0] HDR_WIDTH_3  = 6'd21;
    localparam logic [5:0] HDR_HEIGHT_0 = 6'd22;
    localparam logic [5:0] HDR_HEIGHT_1 = 6'd23;
    localparam logic [5:0] HDR_HEIGHT_2 = 6'd24;
    localparam logic [5:0] HDR_HEIGHT_3 = 6'd25;
    localparam logic [5:0] HDR_LAST     = 6'd53;

    localparam int POS_W = 31;

    // Raw result between parser and gamma stage; color bytes are still
    // raw and are zero on non-pixel words (table entry 0 is 0).
    typedef struct packed {
        t_kind              kind;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [POS_W-1:0]   column;
        logic [POS_W-1:0]   row_index;
        logic [31:0]        image_width;
        logic [31:0]        image_height;
        logic               last_pixel;
    } t_raw_result;

    localparam logic [63:0] Q30 = 64'd1 << 30;

    // Truncating integer square root, elaboration only
    function automatic logic [63:0] int_sqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > n) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // log2 in Q30, fraction by repeated squaring, truncated
    function automatic logic [63:0] log2_q30(input logic [7:0] n);
        logic [63:0] m;
        logic [63:0] res;
        int          e;
        e = 0;
        for (int i = 0; i < 8; i++) begin
            if (n[i]) e = i;
        end
        m = {56'd0, n} << (30 - e);
        res = 64'(e) << 30;
        for (int bit_i = 29; bit_i >= 0; bit_i--) begin
            m = (m * m) >> 30;
            if (m >= 2 * Q30) begin
                m = m >> 1;
                res = res | (64'd1 << bit_i);
            end
        end
        return res;
    endfunction

    // One gamma table entry, 65535 = 1.0
    function automatic logic [15:0] gamma_entry(input int gamma_hundredths,
                                                input logic [7:0] idx);
        logic [63:0] c [31];
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] k;
        logic [63:0] f;
        logic [63:0] v;
        logic [63:0] e;
        int          sh;
        c[0] = '0;
        c[1] = int_sqrt(64'd1 << 59);
        for (int j = 2; j <= 30; j++) c[j] = int_sqrt(c[j-1] << 30);
        if (idx == 8'd0) return 16'd0;
        d = log2_q30(8'd255) - log2_q30(idx);
        t = (d * 64'(gamma_hundredths) + 64'd50) / 100;
        k = t >> 30;
        f = t & (Q30 - 64'd1);
        v = Q30;
        for (int j = 1; j <= 30; j++) begin
            if (f[30-j]) v = (v * c[j] + (Q30 >> 1)) >> 30;
        end
        if (k >= 64'd18) begin
            e = '0;
        end else begin
            sh = 30 + int'(k);
            e = (v * 64'd65535 + (64'd1 << (sh - 1))) >> sh;
            if (e > 64'd65535) e = 64'd65535;
        end
        return e[15:0];
    endfunction

endpackage

/* sv/bmpd_parser.sv */
// bmpd_parser: per-byte header/pixel parse state and the raw result register.
// Depends on bmpd_pkg.
module bmpd_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_file_start,
    output logic                    o_res_valid,
    output bmpd_pkg::t_raw_result   o_res,
    input  logic                    i_res_take
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PIXELS,
        PH_BAD
    } t_phase;

    localparam int PW = bmpd_pkg::POS_W;

    t_phase                 r_phase, n_phase;
    logic [5:0]             r_header_count, n_header_count;
    logic [7:0]             r_first_byte, n_first_byte;
    logic [31:0]            r_width, n_width;
    logic [31:0]            r_height, n_height;
    logic [PW-1:0]          r_col, n_col;
    logic [PW-1:0]          r_row, n_row;
    logic [1:0]             r_channel, n_channel;
    logic [1:0]             r_pad_left, n_pad_left;
    logic [7:0]             r_held_blue, n_held_blue;
    logic [7:0]             r_held_green, n_held_green;

    bmpd_pkg::t_raw_result  r_res, n_res;
    logic                   r_res_valid, n_res_valid;

    logic                   w_accept;
    logic [PW-1:0]          w_col_inc;
    logic [PW-1:0]          w_row_inc;

    // result slot frees when the gamma stage takes it
    assign o_stall     = r_res_valid && !i_res_take;
    assign w_accept    = i_valid && !o_stall;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_phase        = r_phase;
        n_header_count = r_header_count;
        n_first_byte   = r_first_byte;
        n_width        = r_width;
        n_height       = r_height;
        n_col          = r_col;
        n_row          = r_row;
        n_channel      = r_channel;
        n_pad_left     = r_pad_left;
        n_held_blue    = r_held_blue;
        n_held_green   = r_held_green;
        n_res          = '0;
        n_res_valid    = 1'b0;
        w_col_inc      = '0;
        w_row_inc      = '0;

        // file start aborts whatever was going on
        if (i_file_start) begin
            n_phase        = PH_HEADER;
            n_header_count = '0;
            n_width        = '0;
            n_height       = '0;
            n_col          = '0;
            n_row          = '0;
            n_channel      = '0;
            n_pad_left     = '0;
        end

        case (n_phase)
            PH_HEADER: begin
                n_header_count = n_header_count + 6'd1;
                case (n_header_count - 6'd1)
                    bmpd_pkg::HDR_MAGIC_0:  n_first_byte = i_data_byte;
                    bmpd_pkg::HDR_MAGIC_1: begin
                        if (n_first_byte != bmpd_pkg::MAGIC_B ||
                            i_data_byte != bmpd_pkg::MAGIC_M) begin
                            n_phase        = PH_BAD;
                            n_res.kind     = bmpd_pkg::KIND_BAD;
                            n_res_valid    = 1'b1;
                        end
                    end
                    bmpd_pkg::HDR_WIDTH_0:  n_width[7:0]    = i_data_byte;
                    bmpd_pkg::HDR_WIDTH_1:  n_width[15:8]   = i_data_byte;
                    bmpd_pkg::HDR_WIDTH_2:  n_width[23:16]  = i_data_byte;
                    bmpd_pkg::HDR_WIDTH_3:  n_width[31:24]  = i_data_byte;
                    bmpd_pkg::HDR_HEIGHT_0: n_height[7:0]   = i_data_byte;
                    bmpd_pkg::HDR_HEIGHT_1: n_height[15:8]  = i_data_byte;
                    bmpd_pkg::HDR_HEIGHT_2: n_height[23:16] = i_data_byte;
                    bmpd_pkg::HDR_HEIGHT_3: n_height[31:24] = i_data_byte;
                    bmpd_pkg::HDR_LAST: begin
                        n_res.kind         = bmpd_pkg::KIND_HEADER;
                        n_res.image_width  = n_width;
                        n_res.image_height = n_height;
                        n_res_valid        = 1'b1;
                        if (n_width == '0 || n_width[31] ||
                            n_height == '0 || n_height[31]) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase    = PH_PIXELS;
                            n_col      = '0;
                            n_row      = '0;
                            n_channel  = '0;
                            n_pad_left = '0;
                        end
                    end
                    default: ;
                endcase
            end
            PH_PIXELS: begin
                if (n_pad_left != 2'd0) begin
                    n_pad_left = n_pad_left - 2'd1;
                end else if (n_channel == 2'd0) begin
                    n_held_blue = i_data_byte;
                    n_channel   = 2'd1;
                end else if (n_channel == 2'd1) begin
                    n_held_green = i_data_byte;
                    n_channel    = 2'd2;
                end else begin
                    n_channel       = 2'd0;
                    n_res.kind      = bmpd_pkg::KIND_PIXEL;
                    n_res.red       = i_data_byte;
                    n_res.green     = n_held_green;
                    n_res.blue      = n_held_blue;
                    n_res.column    = n_col;
                    n_res.row_index = n_row;
                    n_res_valid     = 1'b1;
                    w_col_inc       = n_col + 1'b1;
                    w_row_inc       = n_row + 1'b1;
                    if ({1'b0, w_col_inc} >= n_width) begin
                        n_col = '0;
                        n_row = w_row_inc;
                        if ({1'b0, w_row_inc} >= n_height) begin
                            n_res.last_pixel = 1'b1;
                            n_phase          = PH_IDLE;
                        end else begin
                            n_pad_left = n_width[1:0];
                        end
                    end else begin
                        n_col = w_col_inc;
                    end
                end
            end
            default: ;  // idle or bad magic: byte dropped
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_header_count <= '0;
            r_first_byte   <= '0;
            r_width        <= '0;
            r_height       <= '0;
            r_col          <= '0;
            r_row          <= '0;
            r_channel      <= '0;
            r_pad_left     <= '0;
            r_held_blue    <= '0;
            r_held_green   <= '0;
            r_res_valid    <= 1'b0;
        end else if (w_accept) begin
            r_phase        <= n_phase;
            r_header_count <= n_header_count;
            r_first_byte   <= n_first_byte;
            r_width        <= n_width;
            r_height       <= n_height;
            r_col          <= n_col;
            r_row          <= n_row;
            r_channel      <= n_channel;
            r_pad_left     <= n_pad_left;
            r_held_blue    <= n_held_blue;
            r_held_green   <= n_held_green;
            r_res_valid    <= n_res_valid;
        end else if (i_res_take) begin
            r_res_valid    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

endmodule

/* sv/bmpd_gamma.sv */
// bmpd_gamma: gamma table lookup of the three channels and the output register.
// Depends on bmpd_pkg.
module bmpd_gamma #(
    parameter int GAMMA_HUNDREDTHS = 220
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_res_valid,
    input  bmpd_pkg::t_raw_result   i_res,
    output logic                    o_res_take,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_kind,
    output logic [15:0]             o_red,
    output logic [15:0]             o_green,
    output logic [15:0]             o_blue,
    output logic [30:0]             o_column,
    output logic [30:0]             o_row_index,
    output logic signed [31:0]      o_image_width,
    output logic signed [31:0]      o_image_height,
    output logic                    o_last_pixel
);

    logic [15:0] w_rom [256];

    // constant table, one entry per generate pass
    for (genvar gi = 0; gi < 256; gi++) begin : g_rom
        localparam logic [15:0] ENTRY = bmpd_pkg::gamma_entry(GAMMA_HUNDREDTHS, 8'(gi));
        assign w_rom[gi] = ENTRY;
    end

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_red, r_green, r_blue;
    logic [30:0] r_column, r_row_index;
    logic [31:0] r_width, r_height;
    logic        r_last;

    assign o_res_take = i_res_valid && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_take) begin
            r_kind      <= i_res.kind;
            r_red       <= w_rom[i_res.red];
            r_green     <= w_rom[i_res.green];
            r_blue      <= w_rom[i_res.blue];
            r_column    <= i_res.column;
            r_row_index <= i_res.row_index;
            r_width     <= i_res.image_width;
            r_height    <= i_res.image_height;
            r_last      <= i_res.last_pixel;
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_column       = r_column;
    assign o_row_index    = r_row_index;
    assign o_image_width  = signed'(r_width);
    assign o_image_height = signed'(r_height);
    assign o_last_pixel   = r_last;

endmodule

/* sv/bmp_pixel_stream_decoder_top.sv */
// bmp_pixel_stream_decoder_top: top level of the 24-bit BMP pixel decoder.
// Depends on bmpd_pkg, bmpd_parser and bmpd_gamma.
//
// Decodes a 24-bit BMP file fed in one byte per word; i_file_start marks the
// first byte of each file and restarts the parse at any time. A bad 'BM'
// magic gives one word of kind 2 and the rest of the file is dropped. Byte 53
// of the 54-byte header gives a kind 1 word with the signed width and height;
// a zero or negative dimension ends the file there. Pixels then come as
// blue/green/red triplets, one kind 0 word per pixel with gamma-corrected
// 16-bit channels (65535 = 1.0), column and row in file order; the width mod 4
// padding bytes after each row are skipped, and o_last_pixel flags the final
// pixel, after which trailing bytes are ignored until the next file start.
// The header pixel-offset field is not used: pixels start right after byte 53.
// Fields that do not apply to a word's kind read zero. Throughput is one
// byte per clock while o_stall is low: the parser updates its counters and
// registers a raw result in the cycle a byte is taken, and the gamma stage
// looks the three channels up in a 256-entry constant table built at
// elaboration from GAMMA_HUNDREDTHS (gamma times 100, 10..500) and registers
// the result word on the output; output stall propagates back to o_stall
// only when both stages hold a word.
module bmp_pixel_stream_decoder_top #(
    parameter int GAMMA_HUNDREDTHS = 220
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input byte channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_file_start,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_kind,
    output logic [15:0]         o_red,
    output logic [15:0]         o_green,
    output logic [15:0]         o_blue,
    output logic [30:0]         o_column,
    output logic [30:0]         o_row_index,
    output logic signed [31:0]  o_image_width,
    output logic signed [31:0]  o_image_height,
    output logic                o_last_pixel
);

    bmpd_pkg::t_raw_result  w_res;
    logic                   w_res_valid;
    logic                   w_res_take;

    // header/pixel parse, raw result register
    bmpd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_take   (w_res_take)
    );

    // gamma lookup and output register
    bmpd_gamma #(
        .GAMMA_HUNDREDTHS (GAMMA_HUNDREDTHS)
    ) u_gamma (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_res_valid    (w_res_valid),
        .i_res          (w_res),
        .o_res_take     (w_res_take),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_column       (o_column),
        .o_row_index    (o_row_index),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_last_pixel   (o_last_pixel)
    );

endmodule

/* test/tb_top.sv */
// tb_top: self-checking testbench for bmp_pixel_stream_decoder_top.
// Depends on bmpd_pkg for result kinds and magic bytes; holds its own gamma
// table and a byte-level decoder model, and checks every output word in order.
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_ITEMS   = 100;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving
    localparam int DRAIN_CYCLES   = 8;     // two-stage pipe plus margin
    localparam int MAX_REPORTS    = 10;

    // decoder phases of the local model
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PIXELS,
        PH_BAD
    } t_phase;

    typedef struct packed {
        bmpd_pkg::t_kind kind;
        logic [15:0]     red;
        logic [15:0]     green;
        logic [15:0]     blue;
        logic [30:0]     column;
        logic [30:0]     row_index;
        logic [31:0]     image_width;
        logic [31:0]     image_height;
        logic            last_pixel;
    } t_decoded_word;

    // DUT signals; every input has a known value from time zero
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic [7:0]         i_data_byte  = 8'h00;
    logic               i_file_start = 1'b0;
    logic               i_stall      = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_kind;
    logic [15:0]        o_red;
    logic [15:0]        o_green;
    logic [15:0]        o_blue;
    logic [30:0]        o_column;
    logic [30:0]        o_row_index;
    logic signed [31:0] o_image_width;
    logic signed [31:0] o_image_height;
    logic               o_last_pixel;

    bmp_pixel_stream_decoder_top #(
        .GAMMA_HUNDREDTHS(220)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_file_start   (i_file_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_column       (o_column),
        .o_row_index    (o_row_index),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_last_pixel   (o_last_pixel)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Gamma table, Q30 fixed point: 2^(-gamma * log2(255/i)) scaled to 16 bits
    // ------------------------------------------------------------------
    logic [15:0] gamma_lut [256];

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] probe;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > x) probe = probe >> 2;
        while (probe != 0) begin
            if (x >= root + probe) begin
                x    = x - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // log2 in Q30; fraction bits by squaring the normalized mantissa
    function automatic logic [63:0] log2_q30(input logic [7:0] n);
        int          msb;
        logic [63:0] mant;
        logic [63:0] acc;
        msb = 0;
        while ((n >> (msb + 1)) != 0) msb++;
        mant = 64'(n) << (30 - msb);
        acc  = 64'(msb) << 30;
        for (int b = 29; b >= 0; b--) begin
            mant = (mant * mant) >> 30;
            if (mant >= (64'd2 << 30)) begin
                mant = mant >> 1;
                acc  = acc | (64'd1 << b);
            end
        end
        return acc;
    endfunction

    initial begin : gamma_build
        logic [63:0] root_tab [31];   // 2^(-2^-j) in Q30
        logic [63:0] log_gap;
        logic [63:0] expo;
        logic [63:0] whole;
        logic [63:0] frac;
        logic [63:0] mant;
        logic [63:0] scaled;
        int          sh;
        root_tab[0] = '0;
        root_tab[1] = isqrt64(64'd1 << 59);
        for (int j = 2; j <= 30; j++) root_tab[j] = isqrt64(root_tab[j-1] << 30);
        gamma_lut[0] = 16'd0;
        for (int i = 1; i < 256; i++) begin
            log_gap = log2_q30(8'd255) - log2_q30(8'(i));
            expo    = (log_gap * 64'd220 + 64'd50) / 64'd100;
            whole   = expo >> 30;
            frac    = expo & ((64'd1 << 30) - 64'd1);
            mant    = 64'd1 << 30;
            for (int j = 1; j <= 30; j++) begin
                if (frac[30-j]) mant = (mant * root_tab[j] + (64'd1 << 29)) >> 30;
            end
            if (whole >= 64'd18) begin
                scaled = '0;
            end else begin
                sh     = 30 + int'(whole);
                scaled = (mant * 64'd65535 + (64'd1 << (sh - 1))) >> sh;
                if (scaled > 64'd65535) scaled = 64'd65535;
            end
            gamma_lut[i] = scaled[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Decoder model: state mirrors the parser, one call per accepted byte
    // ------------------------------------------------------------------
    t_phase        dec_phase   = PH_IDLE;
    logic [5:0]    hdr_pos     = '0;
    logic [31:0]   img_w       = '0;
    logic [31:0]   img_h       = '0;
    logic [31:0]   col_pos     = '0;
    logic [31:0]   row_pos     = '0;
    logic [1:0]    chan_sel    = '0;
    logic [1:0]    pad_count   = '0;
    logic [7:0]    keep_blue   = '0;
    logic [7:0]    keep_green  = '0;
    logic [7:0]    magic_first = '0;

    t_decoded_word expected_words [$];

    task automatic decode_byte(input logic [7:0] b, input logic start);
        t_decoded_word w;
        logic [5:0]    pos;
        w = '0;
        if (start) begin
            dec_phase = PH_HEADER;
            hdr_pos   = '0;
            img_w     = '0;
            img_h     = '0;
            col_pos   = '0;
            row_pos   = '0;
            chan_sel  = '0;
            pad_count = '0;
        end
        if (dec_phase == PH_HEADER) begin
            pos     = hdr_pos;
            hdr_pos = hdr_pos + 6'd1;
            if (pos == bmpd_pkg::HDR_MAGIC_0) begin
                magic_first = b;
            end else if (pos == bmpd_pkg::HDR_MAGIC_1) begin
                if (magic_first != bmpd_pkg::MAGIC_B || b != bmpd_pkg::MAGIC_M) begin
                    dec_phase = PH_BAD;
                    w.kind    = bmpd_pkg::KIND_BAD;
                    expected_words.push_back(w);
                end
            end else if (pos >= bmpd_pkg::HDR_WIDTH_0 && pos <= bmpd_pkg::HDR_WIDTH_3) begin
                img_w = img_w | (32'(b) << (8 * (pos - bmpd_pkg::HDR_WIDTH_0)));
            end else if (pos >= bmpd_pkg::HDR_HEIGHT_0 && pos <= bmpd_pkg::HDR_HEIGHT_3) begin
                img_h = img_h | (32'(b) << (8 * (pos - bmpd_pkg::HDR_HEIGHT_0)));
            end else if (pos == bmpd_pkg::HDR_LAST) begin
                w.kind         = bmpd_pkg::KIND_HEADER;
                w.image_width  = img_w;
                w.image_height = img_h;
                expected_words.push_back(w);
                // zero or negative size: nothing follows
                if (img_w == 0 || img_w[31] || img_h == 0 || img_h[31]) begin
                    dec_phase = PH_IDLE;
                end else begin
                    dec_phase = PH_PIXELS;
                    col_pos   = '0;
                    row_pos   = '0;
                    chan_sel  = '0;
                    pad_count = '0;
                end
            end
        end else if (dec_phase == PH_PIXELS) begin
            if (pad_count != 0) begin
                pad_count = pad_count - 2'd1;
            end else if (chan_sel == 2'd0) begin
                keep_blue = b;
                chan_sel  = 2'd1;
            end else if (chan_sel == 2'd1) begin
                keep_green = b;
                chan_sel   = 2'd2;
            end else begin
                chan_sel    = 2'd0;
                w.kind      = bmpd_pkg::KIND_PIXEL;
                w.red       = gamma_lut[b];
                w.green     = gamma_lut[keep_green];
                w.blue      = gamma_lut[keep_blue];
                w.column    = col_pos[30:0];
                w.row_index = row_pos[30:0];
                col_pos     = col_pos + 32'd1;
                if (col_pos >= img_w) begin
                    col_pos = '0;
                    row_pos = row_pos + 32'd1;
                    if (row_pos >= img_h) begin
                        w.last_pixel = 1'b1;    // image done, rest is dropped
                        dec_phase    = PH_IDLE;
                    end else begin
                        pad_count = img_w[1:0];
                    end
                end
                expected_words.push_back(w);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;
    int bytes_sent = 0;
    int noise_sent = 0;
    int files_sent = 0;
    int holds_done = 0;

    // offer one word and hold it until taken; valid stays up when no gap
    task automatic send_byte(input logic [7:0] data, input logic start);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= data;
        i_file_start <= start;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        decode_byte(data, start);
        bytes_sent++;
    endtask

    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++) send_byte(8'($urandom), 1'b0);
        noise_sent += count;
    endtask

    // first upto bytes of a 54-byte header with the given dimensions
    task automatic send_header(input logic [31:0] w, input logic [31:0] h, input int upto);
        logic [7:0] b;
        files_sent++;
        for (int i = 0; i < upto; i++) begin
            if (i == bmpd_pkg::HDR_MAGIC_0)      b = bmpd_pkg::MAGIC_B;
            else if (i == bmpd_pkg::HDR_MAGIC_1) b = bmpd_pkg::MAGIC_M;
            else if (i >= bmpd_pkg::HDR_WIDTH_0 && i <= bmpd_pkg::HDR_WIDTH_3)
                b = w[8*(i-bmpd_pkg::HDR_WIDTH_0) +: 8];
            else if (i >= bmpd_pkg::HDR_HEIGHT_0 && i <= bmpd_pkg::HDR_HEIGHT_3)
                b = h[8*(i-bmpd_pkg::HDR_HEIGHT_0) +: 8];
            else
                b = 8'($urandom);
            send_byte(b, i == 0);
        end
    endtask

    task automatic send_pixel(input logic [7:0] bl, input logic [7:0] gr, input logic [7:0] rd);
        send_byte(bl, 1'b0);
        send_byte(gr, 1'b0);
        send_byte(rd, 1'b0);
    endtask

    // complete file with random pixels, row padding, then trailing bytes
    task automatic send_file(input int w, input int h, input int trailing);
        send_header(32'(w), 32'(h), 54);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            for (int p = 0; p < (w % 4); p++) send_byte(8'($urandom), 1'b0);
        end
        send_noise(trailing);
    endtask

    task automatic send_bad_magic(input logic [7:0] b0, input logic [7:0] b1, input int tail);
        files_sent++;
        send_byte(b0, 1'b1);
        send_byte(b1, 1'b0);
        send_noise(tail);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall per word, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : receiver
        int wait_n;
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else begin
                wait_n = rx_idle_en ? $urandom_range(0, 10) : 0;
                if (wait_n > 0) begin
                    i_stall <= 1'b1;
                    repeat (wait_n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: in-order compare against the oldest expectation
    // ------------------------------------------------------------------
    int            error_count  = 0;
    int            pixel_words  = 0;
    int            header_words = 0;
    int            bad_words    = 0;
    t_decoded_word got_word;
    t_decoded_word want_word;

    function automatic string word_text(input t_decoded_word w);
        return $sformatf("kind=%0d rgb=%h/%h/%h col=%0d row=%0d dim=%0d x %0d last=%b",
                         w.kind, w.red, w.green, w.blue, w.column, w.row_index,
                         $signed(w.image_width), $signed(w.image_height), w.last_pixel);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_word.kind         = bmpd_pkg::t_kind'(o_kind);
            got_word.red          = o_red;
            got_word.green        = o_green;
            got_word.blue         = o_blue;
            got_word.column       = o_column;
            got_word.row_index    = o_row_index;
            got_word.image_width  = o_image_width;
            got_word.image_height = o_image_height;
            got_word.last_pixel   = o_last_pixel;
            if (expected_words.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: unexpected word %s", $realtime, word_text(got_word));
                error_count++;
            end else begin
                want_word = expected_words.pop_front();
                if (got_word.kind         !== want_word.kind  ||
                    got_word.red          !== want_word.red   ||
                    got_word.green        !== want_word.green ||
                    got_word.blue         !== want_word.blue  ||
                    got_word.column       !== want_word.column ||
                    got_word.row_index    !== want_word.row_index ||
                    got_word.image_width  !== want_word.image_width ||
                    got_word.image_height !== want_word.image_height ||
                    got_word.last_pixel   !== want_word.last_pixel) begin
                    if (error_count < MAX_REPORTS) begin
                        $display("%0t: mismatch, expected %s", $realtime, word_text(want_word));
                        $display("%0t:           actual   %s", $realtime, word_text(got_word));
                    end
                    error_count++;
                end
                case (want_word.kind)
                    bmpd_pkg::KIND_PIXEL:  pixel_words++;
                    bmpd_pkg::KIND_HEADER: header_words++;
                    default:               bad_words++;
                endcase
            end
        end
    end

    // Watchdog: nothing moving on either channel for too long ends the run
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles, %0d words outstanding",
                     quiet_cycles, expected_words.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // bytes with no file start while idle, including a lone 'BM', are dropped
    task automatic test_no_file_bytes();
        send_byte(bmpd_pkg::MAGIC_B, 1'b0);
        send_byte(bmpd_pkg::MAGIC_M, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        noise_sent += 4;
    endtask

    // wrong first byte, wrong second byte, swapped, both wrong; the tail is ignored
    task automatic test_bad_magic();
        send_bad_magic(bmpd_pkg::MAGIC_B, 8'h58, 3);
        send_bad_magic(8'h58, bmpd_pkg::MAGIC_M, 2);
        send_bad_magic(bmpd_pkg::MAGIC_M, bmpd_pkg::MAGIC_B, 0);
        send_bad_magic(8'h00, 8'hFF, 1);
    endtask

    // zero and negative sizes give the header word and nothing more
    task automatic test_nonpositive_dims();
        send_header(32'd0, 32'd5, 54);
        send_noise(4);
        send_header(32'd5, 32'd0, 54);
        send_header(32'h8000_0000, 32'd3, 54);
        send_noise(3);
        send_header(32'd3, 32'hFFFF_FFFF, 54);
    endtask

    // color extremes, every padding amount, trailing bytes after the image
    task automatic test_small_images();
        send_header(32'd1, 32'd1, 54);
        send_pixel(8'h00, 8'hFF, 8'h80);
        send_noise(3);
        send_header(32'd2, 32'd1, 54);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_file(3, 2, 2);
        send_file(4, 2, 0);
        send_file(1, 3, 1);
    endtask

    // file start mid-stream aborts whatever parse is running
    task automatic test_restart();
        send_header(32'd2, 32'd2, 1);
        send_header(32'd2, 32'd2, 20);
        send_header(32'd3, 32'd3, 54);
        send_pixel(8'h11, 8'h22, 8'h33);
        send_byte(8'h44, 1'b0);
        send_file(2, 2, 0);
    endtask

    // no gaps, no stalls: back-to-back bytes and words
    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_file(5, 3, 0);
        send_bad_magic(8'h42, 8'h42, 0);
        send_file(2, 2, 0);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering at full rate
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        send_file(8, 3, 0);
        tx_idle_en = 1'b1;
    endtask

    // mostly well-formed files with random content, plus broken ones
    task automatic test_random_files();
        int         base;
        int         pick;
        logic [31:0] w;
        logic [31:0] h;
        logic [7:0]  b0;
        logic [7:0]  b1;
        base = bytes_sent - noise_sent;
        while ((bytes_sent - noise_sent) - base < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                b0 = $urandom_range(0, 1) ? bmpd_pkg::MAGIC_B : 8'($urandom);
                b1 = $urandom_range(0, 1) ? bmpd_pkg::MAGIC_M : 8'($urandom);
                if (b0 == bmpd_pkg::MAGIC_B && b1 == bmpd_pkg::MAGIC_M) b1 = ~b1;
                send_bad_magic(b0, b1, $urandom_range(0, 4));
            end else if (pick == 1) begin
                // header cut short, dimensions anything
                send_header($urandom, $urandom, $urandom_range(1, 53));
            end else if (pick == 2) begin
                // huge positive size, cut off by the next file start
                w = $urandom & 32'h7FFF_FFFF;
                h = $urandom & 32'h7FFF_FFFF;
                send_header(w, h, 54);
                for (int i = $urandom_range(0, 40); i > 0; i--) send_byte(8'($urandom), 1'b0);
            end else if (pick == 3) begin
                w = $urandom_range(0, 1) ? 32'd0 : ($urandom | 32'h8000_0000);
                h = 32'($urandom_range(1, 5));
                if ($urandom_range(0, 1)) send_header(h, w, 54);
                else                      send_header(w, h, 54);
                send_noise($urandom_range(0, 3));
            end else if (pick == 4) begin
                send_noise($urandom_range(1, 4));
            end else if (pick == 15) begin
                send_file($urandom_range(8, 40), 1, $urandom_range(0, 3));
            end else begin
                send_file($urandom_range(1, 7), $urandom_range(1, 4), $urandom_range(0, 3));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_file_bytes();
        test_bad_magic();
        test_nonpositive_dims();
        test_small_images();
        test_restart();
        test_full_rate();
        test_backpressure();
        test_random_files();

        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d files (bad magic, cut headers, restarts, odd sizes)",
                 bytes_sent, files_sent);
        $display("Checked %0d pixel, %0d header, %0d bad-magic words; %0d long hold(s)",
                 pixel_words, header_words, bad_words, holds_done);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatching words", error_count);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
